### sv/bounded_edit_distance_defines.svh
// Assertion macros shared by the checker of bounded_edit_distance.
// No dependencies; taken in by `include where assertions are written.
`ifndef BOUNDED_EDIT_DISTANCE_DEFINES_SVH
`define BOUNDED_EDIT_DISTANCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bed_pkg.sv
// Package for bounded_edit_distance: widths, defaults, state and control types.
// No dependencies; used by bed_engine and bounded_edit_distance.
`default_nettype none

package bed_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CHAR_W      = 21;
  localparam int DIST_W      = 7;

  localparam logic [DIST_W-1:0] DIST_MAX   = 7'd127;
  localparam logic [DIST_W-1:0] MAXD_RESET = 7'd2;

  // Compute sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROW_START,
    ST_CELL,
    ST_ROW_END,
    ST_DONE
  } state_t;

  // Top to engine control
  typedef struct packed {
    logic start;  // both strings loaded, lengths settled
    logic ack;    // result taken into the output register
  } eng_ctrl_t;

  // Engine to top status
  typedef struct packed {
    logic idle;   // ready to load characters
    logic done;   // result waiting
    logic cut;    // row minimum went over the limit
  } eng_stat_t;

endpackage

`default_nettype wire

### sv/bed_engine.sv
// Edit distance engine: character memories, one row memory and the cell sequencer.
// Depends on bed_pkg.
`default_nettype none

module bed_engine #(
  parameter int MAX_LEN = bed_pkg::MAX_LEN_DEF,
  parameter int LEN_W   = $clog2(MAX_LEN + 1),
  parameter int ADDR_W  = $clog2(MAX_LEN)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bed_pkg::eng_ctrl_t        ctrl,
  input  wire logic                      wr_en,
  input  wire logic                      wr_sel,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic [bed_pkg::CHAR_W-1:0] wr_code,
  input  wire logic [LEN_W-1:0]          first_len,
  input  wire logic [LEN_W-1:0]          second_len,
  input  wire logic [bed_pkg::DIST_W-1:0] max_distance,
  output bed_pkg::eng_stat_t             stat,
  output logic [bed_pkg::DIST_W-1:0]     result_dist
);

  localparam int CW = (LEN_W > bed_pkg::DIST_W) ? LEN_W : bed_pkg::DIST_W;

  // Character stores and the single row store (updated in place)
  logic [bed_pkg::CHAR_W-1:0] first_mem  [MAX_LEN];
  logic [bed_pkg::CHAR_W-1:0] second_mem [MAX_LEN];
  logic [LEN_W-1:0]           row_mem    [MAX_LEN];

  logic [bed_pkg::CHAR_W-1:0] first_q, second_q;
  logic [LEN_W-1:0]           rm_q;

  bed_pkg::state_t state, state_next;

  logic             swap;
  logic [LEN_W-1:0] ncol, nrow, row_j, col;
  logic [LEN_W-1:0] left, diag, row_min;
  logic             cut;

  // Sequencer outputs
  logic              col_ch_en, row_ch_en, rm_en, cell_we;
  logic [ADDR_W-1:0] col_ch_addr, row_ch_addr, rm_addr;

  logic              first_rd_en, second_rd_en;
  logic [ADDR_W-1:0] first_rd_addr, second_rd_addr;

  logic [bed_pkg::CHAR_W-1:0] col_char, row_char;
  logic [LEN_W-1:0]           prior_i, col_m1, row_m1, v;
  logic [LEN_W:0]             up_c, left_c, diag_c, min_ab, min3_c;
  logic                       cost, empty, row_over;

  function automatic logic [bed_pkg::DIST_W-1:0] len_sat(input logic [LEN_W-1:0] x);
    logic [CW-1:0] xe;
    xe = CW'(x);
    len_sat = (xe > CW'(bed_pkg::DIST_MAX)) ? bed_pkg::DIST_MAX : xe[bed_pkg::DIST_W-1:0];
  endfunction

  // Port steering: columns come from the shorter string
  assign first_rd_en    = swap ? row_ch_en   : col_ch_en;
  assign first_rd_addr  = swap ? row_ch_addr : col_ch_addr;
  assign second_rd_en   = swap ? col_ch_en   : row_ch_en;
  assign second_rd_addr = swap ? col_ch_addr : row_ch_addr;
  assign col_char       = swap ? second_q : first_q;
  assign row_char       = swap ? first_q  : second_q;

  // First string store
  always_ff @(posedge clk) begin
    if (wr_en && !wr_sel) begin
      first_mem[wr_addr] <= wr_code;
    end
    if (first_rd_en) begin
      first_q <= first_mem[first_rd_addr];
    end
  end

  // Second string store
  always_ff @(posedge clk) begin
    if (wr_en && wr_sel) begin
      second_mem[wr_addr] <= wr_code;
    end
    if (second_rd_en) begin
      second_q <= second_mem[second_rd_addr];
    end
  end

  // Row store: entry i-1 holds column i of the previous row
  always_ff @(posedge clk) begin
    if (cell_we) begin
      row_mem[col_m1[ADDR_W-1:0]] <= v;
    end
    if (rm_en) begin
      rm_q <= row_mem[rm_addr];
    end
  end

  // Cell arithmetic; the first row's prior values are the column numbers
  assign col_m1   = col - LEN_W'(1);
  assign row_m1   = row_j - LEN_W'(1);
  assign prior_i  = (row_j == LEN_W'(1)) ? col : rm_q;
  assign cost     = (col_char != row_char);
  assign up_c     = {1'b0, prior_i} + (LEN_W+1)'(1);
  assign left_c   = {1'b0, left} + (LEN_W+1)'(1);
  assign diag_c   = {1'b0, diag} + (LEN_W+1)'(cost);
  assign min_ab   = (up_c < left_c) ? up_c : left_c;
  assign min3_c   = (min_ab < diag_c) ? min_ab : diag_c;
  assign v        = min3_c[LEN_W-1:0];
  assign empty    = (first_len == '0) || (second_len == '0);
  assign row_over = CW'(row_min) > CW'(max_distance);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bed_pkg::ST_IDLE:      if (ctrl.start) state_next = bed_pkg::ST_START;
      bed_pkg::ST_START:     state_next = empty ? bed_pkg::ST_DONE : bed_pkg::ST_ROW_START;
      bed_pkg::ST_ROW_START: state_next = bed_pkg::ST_CELL;
      bed_pkg::ST_CELL:      if (col == ncol) state_next = bed_pkg::ST_ROW_END;
      bed_pkg::ST_ROW_END: begin
        if (row_over || (row_j == nrow)) state_next = bed_pkg::ST_DONE;
        else state_next = bed_pkg::ST_ROW_START;
      end
      bed_pkg::ST_DONE:      if (ctrl.ack) state_next = bed_pkg::ST_IDLE;
      default:               state_next = bed_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and status
  always_comb begin
    col_ch_en   = 1'b0;
    row_ch_en   = 1'b0;
    rm_en       = 1'b0;
    cell_we     = 1'b0;
    col_ch_addr = '0;
    row_ch_addr = '0;
    rm_addr     = '0;
    stat        = '0;
    unique case (state)
      bed_pkg::ST_IDLE: stat.idle = 1'b1;
      bed_pkg::ST_ROW_START: begin
        col_ch_en   = 1'b1;
        row_ch_en   = 1'b1;
        rm_en       = 1'b1;
        row_ch_addr = row_m1[ADDR_W-1:0];
      end
      bed_pkg::ST_CELL: begin
        // fetch column i+1 while column i is written back
        col_ch_en   = 1'b1;
        rm_en       = 1'b1;
        cell_we     = 1'b1;
        col_ch_addr = col[ADDR_W-1:0];
        rm_addr     = col[ADDR_W-1:0];
      end
      bed_pkg::ST_DONE: begin
        stat.done = 1'b1;
        stat.cut  = cut;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bed_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      bed_pkg::ST_START: begin
        cut   <= 1'b0;
        row_j <= LEN_W'(1);
        if (first_len == '0) begin
          result_dist <= len_sat(second_len);
        end else if (second_len == '0) begin
          result_dist <= len_sat(first_len);
        end
        swap <= first_len > second_len;
        ncol <= (first_len > second_len) ? second_len : first_len;
        nrow <= (first_len > second_len) ? first_len : second_len;
      end
      bed_pkg::ST_ROW_START: begin
        left    <= row_j;
        diag    <= row_m1;
        row_min <= row_j;
        col     <= LEN_W'(1);
      end
      bed_pkg::ST_CELL: begin
        left    <= v;
        diag    <= prior_i;
        row_min <= (v < row_min) ? v : row_min;
        col     <= col + LEN_W'(1);
      end
      bed_pkg::ST_ROW_END: begin
        if (row_over) begin
          cut         <= 1'b1;
          result_dist <= (max_distance == bed_pkg::DIST_MAX) ? bed_pkg::DIST_MAX
                                                             : max_distance + 7'd1;
        end else if (row_j == nrow) begin
          result_dist <= len_sat(left);
        end
        row_j <= row_j + LEN_W'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/bounded_edit_distance.sv
// Bounded edit distance: input loading, limit register and result register.
// Depends on bed_pkg and bed_engine.
//
// Usage: characters arrive on the s_axis channel, one request each. tuser bit 0
// selects the string (0 first, 1 second), tuser bit 1 says tdata holds a character
// to append, tlast ends the string. Ending the second string starts the
// computation; ending the first does nothing. Characters past MAX_LEN are
// dropped and reported in the result's truncated flag.
// Each pair gives one result on m_axis: tdata the distance, tuser the cut-short
// and truncated flags. cfg_data sets max_distance (reset 2); the user must write
// it only while idle, and the block itself does not enforce this. When either
// string is empty no table is computed; otherwise the engine computes one table
// cell per cycle, reading and writing the row memory together, with a setup and
// a check state per row, and stops after fewer rows when cut short.
// s_axis_tready is low from the ending request until the result is moved into
// the output register. A stalled receiver keeps the result there; the next
// pair loads meanwhile, and its result waits in the engine until the register
// frees. Reset empties both strings, clears the truncated flag and sets the limit
// back to 2; memories keep old contents.
`default_nettype none

module bounded_edit_distance #(
  parameter int MAX_LEN = bed_pkg::MAX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [20:0] char_code, rest zero
  input  wire logic [1:0]  s_axis_tuser,   // [0] string_select, [1] has_char
  input  wire logic        s_axis_tlast,   // end_of_string
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [6:0] distance, [7] zero
  output logic [1:0]       m_axis_tuser,   // [0] cut_short, [1] truncated
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data        // max_distance
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);

  logic                          accept, sel, has, eos, full;
  logic [LEN_W-1:0]              first_len, second_len, sel_len;
  logic                          clip;
  logic [bed_pkg::DIST_W-1:0]    max_distance;
  logic                          start;
  bed_pkg::eng_ctrl_t            ctrl;
  bed_pkg::eng_stat_t            stat;
  logic [bed_pkg::DIST_W-1:0]    eng_dist;
  logic                          wr_en;

  assign sel     = s_axis_tuser[0];
  assign has     = s_axis_tuser[1];
  assign eos     = s_axis_tlast;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign sel_len = sel ? second_len : first_len;
  assign full    = (sel_len == LEN_W'(MAX_LEN));
  assign wr_en   = accept && has && !full;

  assign s_axis_tready = stat.idle && !start;
  assign cfg_ready     = 1'b1;

  assign ctrl.start = start;
  assign ctrl.ack   = stat.done && (!m_axis_tvalid || m_axis_tready);

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= bed_pkg::MAXD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_distance <= cfg_data;
    end
  end

  // String lengths, clip flag and start pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= '0;
      second_len <= '0;
      clip       <= 1'b0;
      start      <= 1'b0;
    end else begin
      start <= accept && eos && sel;
      if (ctrl.ack) begin
        first_len  <= '0;
        second_len <= '0;
        clip       <= 1'b0;
      end else if (accept && has) begin
        if (full) begin
          clip <= 1'b1;
        end else if (sel) begin
          second_len <= second_len + LEN_W'(1);
        end else begin
          first_len <= first_len + LEN_W'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.ack) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ack) begin
      m_axis_tdata <= {1'b0, eng_dist};
      m_axis_tuser <= {clip, stat.cut};
    end
  end

  bed_engine #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W),
    .ADDR_W  (ADDR_W)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .wr_en        (wr_en),
    .wr_sel       (sel),
    .wr_addr      (sel_len[ADDR_W-1:0]),
    .wr_code      (s_axis_tdata[bed_pkg::CHAR_W-1:0]),
    .first_len    (first_len),
    .second_len   (second_len),
    .max_distance (max_distance),
    .stat         (stat),
    .result_dist  (eng_dist)
  );

endmodule

`default_nettype wire

### sv/bed_checker.sv
// Port-level checks for bounded_edit_distance, bound to the top level.
// Depends on bounded_edit_distance_defines.svh.
`default_nettype none
`include "bounded_edit_distance_defines.svh"

module bed_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A stalled result holds
  `BED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // A cut-short result never reports zero
  `BED_ASSERT_NOW(a_cut_nonzero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[6:0] != 7'd0, "cut-short result with zero distance")

  // Ending the second string closes the input while computing
  `BED_ASSERT_NEXT(a_busy_after_end, s_axis_tvalid && s_axis_tready && s_axis_tlast && s_axis_tuser[0], !s_axis_tready, "input open after second string ended")

  // Padding bit of the result stays zero
  `BED_ASSERT_NOW(a_pad_zero, m_axis_tvalid, !m_axis_tdata[7], "result padding bit set")

endmodule

bind bounded_edit_distance bed_checker u_bed_checker (.*);

`default_nettype wire

### test/bounded_edit_distance_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bounded_edit_distance: directed rows, full-length, random pairs.
// Depends on bed_pkg and the bounded_edit_distance RTL; holds its own distance predictor.

module testbench;

  localparam int MAX_LEN       = bed_pkg::MAX_LEN_DEF;
  localparam int CHAR_W        = bed_pkg::CHAR_W;
  localparam int DIST_W        = bed_pkg::DIST_W;
  localparam int CODE_TOP      = 'h10FFFF;
  localparam int RANDOM_TARGET = 1250;
  localparam int BATCH_ROWS    = 150;
  localparam int SETTLE        = 16;
  localparam int HOLD_CYCLES   = 2000;
  // The limit covers the slowest run: all requests, every pair's computation, the full 64x64
  // tables, receiver stalls and the one long hold.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int N_DIRECTED    = 25;

  typedef struct packed {
    logic              sel;
    logic              has;
    logic [CHAR_W-1:0] code;
    logic              last;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              cut;
    logic              trunc;
  } result_t;

  typedef struct packed {
    logic              sel;
    logic              has;
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              typed;
    logic [DIST_W-1:0] distance;
    logic              cut;
    logic              trunc;
  } dir_row_t;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_RANDOM,
    SINK_PERIODIC
  } sink_mode_e;

  // Directed rows: fields, then an expectation where it is obvious (limit at reset value 2)
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // ignored request, then a bare end of the first string
    '{1'b0, 1'b0, 21'h10FFFF, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 21'h000000, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0},
    // both strings empty
    '{1'b1, 1'b0, 21'h0ABCDE, 1'b1, 1'b1, 7'd0, 1'b0, 1'b0},
    // first empty, second "xyz", char and end together
    '{1'b1, 1'b1, 21'h000078, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000079, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h00007A, 1'b1, 1'b1, 7'd3, 1'b0, 1'b0},
    // second empty, first "pqrs": never cut even above the limit
    '{1'b0, 1'b1, 21'h000070, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 21'h000071, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 21'h000072, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 21'h000073, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 21'h000000, 1'b1, 1'b1, 7'd4, 1'b0, 1'b0},
    // "ab" vs "cdef" interleaved: third row minimum 3 exceeds 2
    '{1'b0, 1'b1, 21'h000061, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000063, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 21'h000062, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000064, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000065, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000066, 1'b1, 1'b1, 7'd3, 1'b1, 1'b0},
    // extreme codes, equal strings
    '{1'b0, 1'b1, 21'h10FFFF, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 21'h000000, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h10FFFF, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000000, 1'b1, 1'b1, 7'd0, 1'b0, 1'b0},
    // "ab" vs "ba", equal lengths, left to the predictor
    '{1'b0, 1'b1, 21'h000061, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 21'h000062, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000062, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 21'h000061, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0}
  };

  localparam logic [DIST_W-1:0] LIMIT_PLAN [4] = '{7'd0, 7'd64, 7'd127, 7'd1};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;   // [20:0] char_code, rest zero
  logic [1:0]        s_axis_tuser = '0;   // [0] string_select, [1] has_char
  logic              s_axis_tlast = 1'b0; // end_of_string
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [6:0] distance, [7] zero
  logic [1:0]        m_axis_tuser;        // [0] cut_short, [1] truncated
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DIST_W-1:0] cfg_data = '0;       // max_distance

  bounded_edit_distance #(.MAX_LEN(MAX_LEN)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirrors the block's string stores and limit register
  logic [CHAR_W-1:0] first_str  [MAX_LEN];
  logic [CHAR_W-1:0] second_str [MAX_LEN];
  int unsigned       first_len  = 0;
  int unsigned       second_len = 0;
  bit                clip_seen  = 1'b0;
  logic [DIST_W-1:0] limit_reg  = bed_pkg::MAXD_RESET;

  result_t     due_results [$];
  result_t     typed_answer [int];
  int          results_due    = 0;
  int          requests_taken = 0;
  int          results_seen   = 0;
  int          cut_count      = 0;
  int          clip_count     = 0;
  int          limit_writes   = 0;
  int          fail_count     = 0;
  int          random_reqs    = 0;
  int          burst_left     = 0;
  int          cycles         = 0;
  bit          hold_wanted    = 1'b0;

  logic [CHAR_W-1:0] pair_alpha [4];
  bit                pair_wide;

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Apply one request to the predictor; returns 1 with the distance when the pair ends
  function automatic bit predict_distance(input req_t r, output result_t res);
    logic [CHAR_W-1:0] col_c [MAX_LEN];
    logic [CHAR_W-1:0] row_c [MAX_LEN];
    int unsigned prev_row [MAX_LEN+1];
    int unsigned this_row [MAX_LEN+1];
    int unsigned n_col, n_row, row_min, cost, cell_val, d;
    bit cut;
    res = '0;
    if (r.has) begin
      if (r.sel) begin
        if (second_len < MAX_LEN) begin
          second_str[second_len] = r.code;
          second_len++;
        end else clip_seen = 1'b1;
      end else begin
        if (first_len < MAX_LEN) begin
          first_str[first_len] = r.code;
          first_len++;
        end else clip_seen = 1'b1;
      end
    end
    if (!(r.last && r.sel)) return 1'b0;

    cut = 1'b0;
    d = 0;
    if (first_len == 0) d = second_len;
    else if (second_len == 0) d = first_len;
    else begin
      // columns over the shorter string, the first one on a tie
      if (first_len <= second_len) begin
        col_c = first_str;  n_col = first_len;
        row_c = second_str; n_row = second_len;
      end else begin
        col_c = second_str; n_col = second_len;
        row_c = first_str;  n_row = first_len;
      end
      for (int i = 0; i <= n_col; i++) prev_row[i] = i;
      for (int j = 1; j <= n_row && !cut; j++) begin
        this_row[0] = j;
        row_min = j;
        for (int i = 1; i <= n_col; i++) begin
          cost = (col_c[i-1] == row_c[j-1]) ? 0 : 1;
          cell_val = prev_row[i-1] + cost;
          if (prev_row[i] + 1 < cell_val) cell_val = prev_row[i] + 1;
          if (this_row[i-1] + 1 < cell_val) cell_val = this_row[i-1] + 1;
          this_row[i] = cell_val;
          if (cell_val < row_min) row_min = cell_val;
        end
        if (row_min > limit_reg) begin
          cut = 1'b1;
          d = limit_reg + 1;
        end else prev_row = this_row;
      end
      if (!cut) d = prev_row[n_col];
    end
    if (d > bed_pkg::DIST_MAX) d = bed_pkg::DIST_MAX;
    res.distance = d[DIST_W-1:0];
    res.cut      = cut;
    res.trunc    = clip_seen;
    first_len  = 0;
    second_len = 0;
    clip_seen  = 1'b0;
    return 1'b1;
  endfunction

  // Track register writes and accepted requests, check results in order
  always @(posedge clk) begin : monitor
    req_t    taken;
    result_t res;
    if (!rst) begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        taken = '{sel: s_axis_tuser[0], has: s_axis_tuser[1],
                  code: s_axis_tdata[CHAR_W-1:0], last: s_axis_tlast};
        requests_taken++;
        if (predict_distance(taken, res)) begin
          if (typed_answer.exists(results_due)) res = typed_answer[results_due];
          results_due++;
          due_results.insert(due_results.size(), res);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser[0]) cut_count++;
        if (m_axis_tuser[1]) clip_count++;
        if (due_results.size() == 0) begin
          flag_failure($sformatf("unexpected result tdata %0h tuser %0b",
                                 m_axis_tdata, m_axis_tuser));
        end else begin
          res = due_results.pop_front();
          if (m_axis_tdata !== {1'b0, res.distance} || m_axis_tuser[0] !== res.cut ||
              m_axis_tuser[1] !== res.trunc)
            flag_failure($sformatf(
              "result %0d: expected distance %0d cut %0b clipped %0b, got tdata %0h cut %0b clipped %0b",
              results_seen, res.distance, res.cut, res.trunc,
              m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]));
        end
      end
    end
  end

  // Result sink: steady, random and periodic stretches, plus one long hold
  sink_mode_e sink_mode = SINK_STEADY;
  int         sink_left = 0;
  int         sink_step = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_mode     <= SINK_STEADY;
      sink_left     <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_wanted && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 2));
        sink_left <= $urandom_range(50, 400);
      end else sink_left <= sink_left - 1;
      sink_step <= (sink_step == 4) ? 0 : sink_step + 1;
      case (sink_mode)
        SINK_STEADY:   m_axis_tready <= 1'b1;
        SINK_RANDOM:   m_axis_tready <= ($urandom_range(0, 2) != 0);
        SINK_PERIODIC: m_axis_tready <= (sink_step < 3);
        default:       m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, due_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer requests in bursts with random gaps; valid stays high across back-to-back bursts
  task automatic send_requests(ref req_t reqs[$]);
    int gap;
    foreach (reqs[k]) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {3'b000, reqs[k].code};
      s_axis_tuser  <= {reqs[k].has, reqs[k].sel};
      s_axis_tlast  <= reqs[k].last;
      do @(posedge clk); while (!s_axis_tready);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(40, 150);
          gap = 0;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap = $urandom_range(0, 12);
        end
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    repeat (2) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    if (pair_wide) return CHAR_W'($urandom_range(0, CODE_TOP));
    return pair_alpha[$urandom_range(0, 3)];
  endfunction

  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 0;
    if (roll < 78) return $urandom_range(1, 8);
    if (roll < 98) return $urandom_range(9, 20);
    return $urandom_range(65, 68);
  endfunction

  // One pair: characters of both strings interleaved, second string's end last.
  // With mutate the second string is the first with a few edits.
  task automatic add_pair(ref req_t reqs[$], input int len_a, input int len_b,
                          input bit mutate);
    logic [CHAR_W-1:0] str_a [$];
    logic [CHAR_W-1:0] str_b [$];
    int ia, ib, body_b, pos, roll;
    bit end_with_char;
    req_t r;
    pair_wide = ($urandom_range(0, 4) == 0);
    foreach (pair_alpha[k]) pair_alpha[k] = CHAR_W'($urandom_range(0, CODE_TOP));
    repeat (len_a) str_a.insert(str_a.size(), pick_char());
    if (mutate) begin
      str_b = str_a;
      repeat ($urandom_range(0, 4)) begin
        pos  = $urandom_range(0, str_b.size());
        roll = $urandom_range(0, 2);
        if (roll == 0) str_b.insert(pos, pick_char());
        else if (pos < str_b.size()) begin
          if (roll == 1) str_b.delete(pos);
          else str_b[pos] = pick_char();
        end
      end
    end else repeat (len_b) str_b.insert(str_b.size(), pick_char());

    end_with_char = (str_b.size() != 0) && ($urandom_range(0, 1) == 1);
    body_b = end_with_char ? str_b.size() - 1 : str_b.size();
    ia = 0;
    ib = 0;
    while (ia < str_a.size() || ib < body_b) begin
      // ignored requests: no character, at most an end of the first string
      if ($urandom_range(0, 19) == 0) begin
        r.sel  = 1'($urandom_range(0, 1));
        r.has  = 1'b0;
        r.code = CHAR_W'($urandom_range(0, CODE_TOP));
        r.last = !r.sel && ($urandom_range(0, 1) == 1);
        reqs.insert(reqs.size(), r);
      end
      if (ib >= body_b || (ia < str_a.size() && $urandom_range(0, 1) == 1)) begin
        // ending the first string anywhere leaves it open
        reqs.insert(reqs.size(), '{1'b0, 1'b1, str_a[ia], ($urandom_range(0, 5) == 0)});
        ia++;
      end else begin
        reqs.insert(reqs.size(), '{1'b1, 1'b1, str_b[ib], 1'b0});
        ib++;
      end
      random_reqs++;
    end
    if (end_with_char) reqs.insert(reqs.size(), '{1'b1, 1'b1, str_b[body_b], 1'b1});
    else reqs.insert(reqs.size(), '{1'b1, 1'b0, CHAR_W'($urandom_range(0, CODE_TOP)), 1'b1});
    random_reqs++;
  endtask

  initial begin : run
    req_t batch [$];
    int   pairs_planned;
    int   phase;
    logic [DIST_W-1:0] lim;
    pairs_planned = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset limit
    foreach (DIRECTED[k]) begin
      batch.insert(batch.size(),
                   '{DIRECTED[k].sel, DIRECTED[k].has, DIRECTED[k].code, DIRECTED[k].last});
      if (DIRECTED[k].sel && DIRECTED[k].last) begin
        if (DIRECTED[k].typed)
          typed_answer[pairs_planned] = '{DIRECTED[k].distance, DIRECTED[k].cut,
                                          DIRECTED[k].trunc};
        pairs_planned++;
      end
    end
    send_requests(batch);
    drain_results();

    // Full-length strings: clipping on either side, a full string vs an edited copy
    write_limit(7'd64);
    batch.delete();
    add_pair(batch, 66, 3, 1'b0);
    add_pair(batch, 0, 65, 1'b0);
    add_pair(batch, MAX_LEN, MAX_LEN, 1'b1);
    send_requests(batch);
    drain_results();

    // Random pairs, a new limit per batch
    random_reqs = 0;
    phase = 0;
    while (random_reqs < RANDOM_TARGET) begin
      if (phase < 4) lim = LIMIT_PLAN[phase];
      else if ($urandom_range(0, 3) == 0) lim = DIST_W'($urandom_range(0, 64));
      else lim = DIST_W'($urandom_range(0, 6));
      write_limit(lim);
      if (phase == 2) hold_wanted <= 1'b1;
      batch.delete();
      while (batch.size() < BATCH_ROWS)
        add_pair(batch, pick_len(), pick_len(), ($urandom_range(0, 1) == 1));
      send_requests(batch);
      drain_results();
      phase++;
    end

    repeat (50) @(posedge clk);
    if (due_results.size() != 0)
      flag_failure($sformatf("%0d results never arrived", due_results.size()));
    $display("Run covered %0d requests and %0d distances (%0d cut short, %0d clipped)",
             requests_taken, results_seen, cut_count, clip_count);
    $display("over %0d limit settings, including 0, 64 and 127.", limit_writes + 1);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("Mismatches: %0d", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/bed_pkg.sv
sv/bed_engine.sv
sv/bounded_edit_distance.sv
sv/bed_checker.sv
test/bounded_edit_distance_tb.sv
